// ===== rtl/core/kf2_pkg.sv =====
package kf2_pkg;

    localparam int DW = 32;
    localparam int FRAC = 16;
    localparam int MW = 2 * DW - FRAC;          // quotient / shifted product magnitude
    localparam int CFG_AW = 4;
    localparam int NUM_CFG = 8;
    localparam int PC_W = 6;
    localparam int PROG_LEN = 54;
    localparam int RAM_DEPTH = 32;
    localparam int RAM_AW = $clog2(RAM_DEPTH);
    localparam int CODE_W = 6;

    localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

    localparam logic [DW-1:0] PROC_NOISE_RST = DW'(655);
    localparam logic [DW-1:0] MEAS_NOISE_RST = DW'(6554);
    localparam logic [DW-1:0] COV_RST = DW'(6554);

    // register indexes
    localparam logic [CFG_AW-1:0] CFG_Q00 = 4'd0;
    localparam logic [CFG_AW-1:0] CFG_Q01 = 4'd1;
    localparam logic [CFG_AW-1:0] CFG_Q10 = 4'd2;
    localparam logic [CFG_AW-1:0] CFG_Q11 = 4'd3;
    localparam logic [CFG_AW-1:0] CFG_R00 = 4'd4;
    localparam logic [CFG_AW-1:0] CFG_R01 = 4'd5;
    localparam logic [CFG_AW-1:0] CFG_R10 = 4'd6;
    localparam logic [CFG_AW-1:0] CFG_R11 = 4'd7;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CHK = 3'd4
    } op_t;

    // operand codes: msb clear selects scratch ram, msb set selects named registers
    localparam logic [CODE_W-1:0] T_PP0 = 6'h00;
    localparam logic [CODE_W-1:0] T_PP1 = 6'h01;
    localparam logic [CODE_W-1:0] T_PP2 = 6'h02;
    localparam logic [CODE_W-1:0] T_PP3 = 6'h03;
    localparam logic [CODE_W-1:0] T_S0 = 6'h04;
    localparam logic [CODE_W-1:0] T_S1 = 6'h05;
    localparam logic [CODE_W-1:0] T_S2 = 6'h06;
    localparam logic [CODE_W-1:0] T_S3 = 6'h07;
    localparam logic [CODE_W-1:0] T_A = 6'h08;
    localparam logic [CODE_W-1:0] T_B = 6'h09;
    localparam logic [CODE_W-1:0] T_DET = 6'h0A;
    localparam logic [CODE_W-1:0] T_N0 = 6'h0B;
    localparam logic [CODE_W-1:0] T_N1 = 6'h0C;
    localparam logic [CODE_W-1:0] T_N2 = 6'h0D;
    localparam logic [CODE_W-1:0] T_N3 = 6'h0E;
    localparam logic [CODE_W-1:0] T_K0 = 6'h0F;
    localparam logic [CODE_W-1:0] T_K1 = 6'h10;
    localparam logic [CODE_W-1:0] T_K2 = 6'h11;
    localparam logic [CODE_W-1:0] T_K3 = 6'h12;
    localparam logic [CODE_W-1:0] T_I0 = 6'h13;
    localparam logic [CODE_W-1:0] T_I1 = 6'h14;

    localparam logic [CODE_W-1:0] X_Q0 = 6'h20;
    localparam logic [CODE_W-1:0] X_Q1 = 6'h21;
    localparam logic [CODE_W-1:0] X_Q2 = 6'h22;
    localparam logic [CODE_W-1:0] X_Q3 = 6'h23;
    localparam logic [CODE_W-1:0] X_R0 = 6'h24;
    localparam logic [CODE_W-1:0] X_R1 = 6'h25;
    localparam logic [CODE_W-1:0] X_R2 = 6'h26;
    localparam logic [CODE_W-1:0] X_R3 = 6'h27;
    localparam logic [CODE_W-1:0] X_C0 = 6'h28;
    localparam logic [CODE_W-1:0] X_C1 = 6'h29;
    localparam logic [CODE_W-1:0] X_C2 = 6'h2A;
    localparam logic [CODE_W-1:0] X_C3 = 6'h2B;
    localparam logic [CODE_W-1:0] X_E0 = 6'h2C;
    localparam logic [CODE_W-1:0] X_E1 = 6'h2D;
    localparam logic [CODE_W-1:0] X_Z0 = 6'h2E;
    localparam logic [CODE_W-1:0] X_Z1 = 6'h2F;

    typedef struct packed {
        op_t op;
        logic [CODE_W-1:0] a;
        logic [CODE_W-1:0] b;
        logic [CODE_W-1:0] dst;
    } uop_t;

    typedef struct packed {
        logic start;
        op_t op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic clip;
    } alu_rsp_t;

    function automatic uop_t mk(op_t op, logic [CODE_W-1:0] a, logic [CODE_W-1:0] b,
                                logic [CODE_W-1:0] dst);
        uop_t u;
        u.op = op;
        u.a = a;
        u.b = b;
        u.dst = dst;
        return u;
    endfunction

    function automatic uop_t prog(logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            6'd0: u = mk(OP_ADD, X_C0, X_Q0, T_PP0);
            6'd1: u = mk(OP_ADD, X_C1, X_Q1, T_PP1);
            6'd2: u = mk(OP_ADD, X_C2, X_Q2, T_PP2);
            6'd3: u = mk(OP_ADD, X_C3, X_Q3, T_PP3);
            6'd4: u = mk(OP_ADD, T_PP0, X_R0, T_S0);
            6'd5: u = mk(OP_ADD, T_PP1, X_R1, T_S1);
            6'd6: u = mk(OP_ADD, T_PP2, X_R2, T_S2);
            6'd7: u = mk(OP_ADD, T_PP3, X_R3, T_S3);
            6'd8: u = mk(OP_MUL, T_S0, T_S3, T_A);
            6'd9: u = mk(OP_MUL, T_S1, T_S2, T_B);
            6'd10: u = mk(OP_SUB, T_A, T_B, T_DET);
            6'd11: u = mk(OP_CHK, T_DET, T_DET, T_DET);
            6'd12: u = mk(OP_MUL, T_PP0, T_S3, T_A);
            6'd13: u = mk(OP_MUL, T_PP1, T_S2, T_B);
            6'd14: u = mk(OP_SUB, T_A, T_B, T_N0);
            6'd15: u = mk(OP_MUL, T_PP1, T_S0, T_A);
            6'd16: u = mk(OP_MUL, T_PP0, T_S1, T_B);
            6'd17: u = mk(OP_SUB, T_A, T_B, T_N1);
            6'd18: u = mk(OP_MUL, T_PP2, T_S3, T_A);
            6'd19: u = mk(OP_MUL, T_PP3, T_S2, T_B);
            6'd20: u = mk(OP_SUB, T_A, T_B, T_N2);
            6'd21: u = mk(OP_MUL, T_PP3, T_S0, T_A);
            6'd22: u = mk(OP_MUL, T_PP2, T_S1, T_B);
            6'd23: u = mk(OP_SUB, T_A, T_B, T_N3);
            6'd24: u = mk(OP_DIV, T_N0, T_DET, T_K0);
            6'd25: u = mk(OP_DIV, T_N1, T_DET, T_K1);
            6'd26: u = mk(OP_DIV, T_N2, T_DET, T_K2);
            6'd27: u = mk(OP_DIV, T_N3, T_DET, T_K3);
            6'd28: u = mk(OP_SUB, X_Z0, X_E0, T_I0);
            6'd29: u = mk(OP_SUB, X_Z1, X_E1, T_I1);
            6'd30: u = mk(OP_MUL, T_K0, T_I0, T_A);
            6'd31: u = mk(OP_MUL, T_K1, T_I1, T_B);
            6'd32: u = mk(OP_ADD, T_A, T_B, T_A);
            6'd33: u = mk(OP_ADD, X_E0, T_A, X_E0);
            6'd34: u = mk(OP_MUL, T_K2, T_I0, T_A);
            6'd35: u = mk(OP_MUL, T_K3, T_I1, T_B);
            6'd36: u = mk(OP_ADD, T_A, T_B, T_A);
            6'd37: u = mk(OP_ADD, X_E1, T_A, X_E1);
            6'd38: u = mk(OP_MUL, T_K0, T_PP0, T_A);
            6'd39: u = mk(OP_MUL, T_K1, T_PP2, T_B);
            6'd40: u = mk(OP_ADD, T_A, T_B, T_A);
            6'd41: u = mk(OP_SUB, T_PP0, T_A, X_C0);
            6'd42: u = mk(OP_MUL, T_K0, T_PP1, T_A);
            6'd43: u = mk(OP_MUL, T_K1, T_PP3, T_B);
            6'd44: u = mk(OP_ADD, T_A, T_B, T_A);
            6'd45: u = mk(OP_SUB, T_PP1, T_A, X_C1);
            6'd46: u = mk(OP_MUL, T_K2, T_PP0, T_A);
            6'd47: u = mk(OP_MUL, T_K3, T_PP2, T_B);
            6'd48: u = mk(OP_ADD, T_A, T_B, T_A);
            6'd49: u = mk(OP_SUB, T_PP2, T_A, X_C2);
            6'd50: u = mk(OP_MUL, T_K2, T_PP1, T_A);
            6'd51: u = mk(OP_MUL, T_K3, T_PP3, T_B);
            6'd52: u = mk(OP_ADD, T_A, T_B, T_A);
            6'd53: u = mk(OP_SUB, T_PP3, T_A, X_C3);
            default: u = mk(OP_ADD, T_A, T_A, T_A);
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/core/kf2_ram.sv =====
module kf2_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== rtl/core/kf2_alu.sv =====
module kf2_alu (
    input  logic                     clk,
    input  logic                     rst_n,
    input  kf2_pkg::alu_req_t        req,
    input  logic [kf2_pkg::DW-1:0]   a,
    input  logic [kf2_pkg::DW-1:0]   b,
    output kf2_pkg::alu_rsp_t        rsp,
    output logic [kf2_pkg::DW-1:0]   result
);

    localparam int DW = kf2_pkg::DW;
    localparam int MW = kf2_pkg::MW;
    localparam int CNT_W = $clog2(MW + 1);

    // signed magnitude back to a clipped two's complement word, clip flag on top
    function automatic logic [DW:0] from_mag(logic neg, logic [MW-1:0] m);
        logic [MW-1:0] lim;
        logic [MW-1:0] neg_m;
        lim = (MW'(1) << (DW - 1)) - (neg ? MW'(0) : MW'(1));
        neg_m = MW'(0) - m;
        if (m > lim)
        begin
            return {1'b1, neg ? kf2_pkg::SMIN : kf2_pkg::SMAX};
        end
        return {1'b0, neg ? neg_m[DW-1:0] : m[DW-1:0]};
    endfunction

    logic                done_reg;
    logic                clip_reg;
    logic [DW-1:0]       res_reg;
    logic                div_busy_reg;
    logic [CNT_W-1:0]    div_cnt_reg;
    logic [MW-1:0]       div_num_reg;
    logic [DW-1:0]       div_rem_reg;
    logic [DW-1:0]       div_den_reg;
    logic                div_neg_reg;

    logic [DW:0]         sum;
    logic                sum_clip;
    logic [DW-1:0]       sum_val;
    logic signed [2*DW-1:0] prod;
    logic [2*DW-1:0]     prod_mag;
    logic [DW:0]         mul_res;
    logic [DW-1:0]       a_mag;
    logic [DW-1:0]       b_mag;
    logic [DW:0]         rem_sh;
    logic                rem_ge;
    logic [DW:0]         rem_sub;
    logic [MW-1:0]       num_next;
    logic [DW:0]         div_res;

    always_comb
    begin
        if (req.op == kf2_pkg::OP_SUB)
        begin
            sum = {a[DW-1], a} - {b[DW-1], b};
        end
        else
        begin
            sum = {a[DW-1], a} + {b[DW-1], b};
        end
        sum_clip = sum[DW] != sum[DW-1];
        sum_val = sum_clip ? (sum[DW] ? kf2_pkg::SMIN : kf2_pkg::SMAX) : sum[DW-1:0];

        prod = $signed(a) * $signed(b);
        prod_mag = prod[2*DW-1] ? (2*DW)'(0) - prod : prod;
        mul_res = from_mag(a[DW-1] ^ b[DW-1], prod_mag[kf2_pkg::FRAC +: MW]);

        a_mag = a[DW-1] ? DW'(0) - a : a;
        b_mag = b[DW-1] ? DW'(0) - b : b;

        // one restoring step a cycle
        rem_sh = {div_rem_reg, div_num_reg[MW-1]};
        rem_ge = rem_sh >= {1'b0, div_den_reg};
        rem_sub = rem_ge ? rem_sh - {1'b0, div_den_reg} : rem_sh;
        num_next = {div_num_reg[MW-2:0], rem_ge};
        div_res = from_mag(div_neg_reg, num_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            div_busy_reg <= 1'b0;
            div_cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg - CNT_W'(1);
                if (div_cnt_reg == CNT_W'(1))
                begin
                    div_busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (req.start)
            begin
                if (req.op == kf2_pkg::OP_DIV)
                begin
                    div_busy_reg <= 1'b1;
                    div_cnt_reg <= CNT_W'(MW);
                end
                else
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_busy_reg)
        begin
            div_num_reg <= num_next;
            div_rem_reg <= rem_sub[DW-1:0];
            if (div_cnt_reg == CNT_W'(1))
            begin
                res_reg <= div_res[DW-1:0];
                clip_reg <= div_res[DW];
            end
        end
        else if (req.start)
        begin
            case (req.op)
                kf2_pkg::OP_MUL:
                begin
                    res_reg <= mul_res[DW-1:0];
                    clip_reg <= mul_res[DW];
                end
                kf2_pkg::OP_DIV:
                begin
                    div_num_reg <= MW'(a_mag) << kf2_pkg::FRAC;
                    div_rem_reg <= '0;
                    div_den_reg <= b_mag;
                    div_neg_reg <= a[DW-1] ^ b[DW-1];
                end
                default:
                begin
                    res_reg <= sum_val;
                    clip_reg <= sum_clip;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.clip = clip_reg;
    assign result = res_reg;

endmodule

// ===== rtl/core/kalman_filter_2ch_random_walk.sv =====
// Two-channel Kalman filter, identity state model, signed Q16.16 throughout.
// One transaction on the input carries a measurement pair; one transaction on
// the output returns the updated estimate with singular and saturated flags.
// A small sequencer walks a 54-step micro-program through one shared unit
// (saturating add/sub, 32x32 multiply, bit-serial divider) with scratch values
// in a two-read-port ram. Add, subtract and multiply steps pass through operand
// read, issue and write-back; the determinant check has only read and test;
// each of the four gain divides waits for 48 quotient bits from the divider
// between issue and write-back. A zero determinant ends the program after
// 12 steps. Noise registers Q (index 0..3) and R (index 4..7) must be
// written only while idle; the block itself does not enforce it.
module kalman_filter_2ch_random_walk (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [31:0]                   meas_a,
    input  logic [31:0]                   meas_b,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [31:0]                   est_a,
    output logic [31:0]                   est_b,
    output logic                          singular,
    output logic                          saturated,
    input  logic                          cfg_we,
    input  logic [kf2_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [31:0]                   cfg_data
);

    localparam int DW = kf2_pkg::DW;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_EXEC  = 6'b000100,
        ST_WAIT  = 6'b001000,
        ST_DONE  = 6'b010000,
        ST_SING  = 6'b100000
    } state_t;

    state_t                      state_reg, state_next;
    logic [kf2_pkg::PC_W-1:0]    pc_reg;
    logic [DW-1:0]               q_reg [4];
    logic [DW-1:0]               r_reg [4];
    logic [DW-1:0]               cov_reg [4];
    logic [DW-1:0]               est_reg [2];
    logic [DW-1:0]               z_reg [2];
    logic                        clip_reg;
    logic [DW-1:0]               ext_a_reg, ext_b_reg;
    logic                        out_valid_reg;
    logic [31:0]                 est_a_reg, est_b_reg;
    logic                        singular_reg, saturated_reg;

    kf2_pkg::uop_t               uop;
    kf2_pkg::alu_req_t           alu_req;
    kf2_pkg::alu_rsp_t           alu_rsp;
    logic [DW-1:0]               alu_result;
    logic [DW-1:0]               ram_a, ram_b;
    logic [DW-1:0]               opnd_a, opnd_b;
    logic                        ram_we;
    logic                        in_take, out_free;
    logic                        last_step;

    function automatic logic [DW-1:0] ext_sel(
        logic [3:0] idx,
        logic [DW-1:0] q0, logic [DW-1:0] q1, logic [DW-1:0] q2, logic [DW-1:0] q3,
        logic [DW-1:0] r0, logic [DW-1:0] r1, logic [DW-1:0] r2, logic [DW-1:0] r3,
        logic [DW-1:0] c0, logic [DW-1:0] c1, logic [DW-1:0] c2, logic [DW-1:0] c3,
        logic [DW-1:0] e0, logic [DW-1:0] e1, logic [DW-1:0] z0, logic [DW-1:0] z1);
        logic [DW-1:0] v;
        case (idx)
            4'd0: v = q0;
            4'd1: v = q1;
            4'd2: v = q2;
            4'd3: v = q3;
            4'd4: v = r0;
            4'd5: v = r1;
            4'd6: v = r2;
            4'd7: v = r3;
            4'd8: v = c0;
            4'd9: v = c1;
            4'd10: v = c2;
            4'd11: v = c3;
            4'd12: v = e0;
            4'd13: v = e1;
            4'd14: v = z0;
            default: v = z1;
        endcase
        return v;
    endfunction

    // current micro-op straight from the program rom
    assign uop = kf2_pkg::prog(pc_reg);
    assign last_step = pc_reg == kf2_pkg::PC_W'(kf2_pkg::PROG_LEN - 1);

    // operand msb chooses named register over scratch ram; pc holds through the op
    assign opnd_a = uop.a[kf2_pkg::CODE_W-1] ? ext_a_reg : ram_a;
    assign opnd_b = uop.b[kf2_pkg::CODE_W-1] ? ext_b_reg : ram_b;

    assign in_take = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = state_reg != ST_IDLE;

    assign alu_req.start = (state_reg == ST_EXEC) && (uop.op != kf2_pkg::OP_CHK);
    assign alu_req.op = uop.op;

    // scratch results go to ram, state results to the flops below
    assign ram_we = (state_reg == ST_WAIT) && alu_rsp.done && !uop.dst[kf2_pkg::CODE_W-1];

    kf2_ram #(
        .WIDTH(DW),
        .DEPTH(kf2_pkg::RAM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (uop.dst[kf2_pkg::RAM_AW-1:0]),
        .wdata   (alu_result),
        .raddr_a (uop.a[kf2_pkg::RAM_AW-1:0]),
        .raddr_b (uop.b[kf2_pkg::RAM_AW-1:0]),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    kf2_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (opnd_a),
        .b      (opnd_b),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (uop.op == kf2_pkg::OP_CHK)
                begin
                    state_next = (opnd_a == '0) ? ST_SING : ST_READ;
                end
                else
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    state_next = last_step ? ST_DONE : ST_READ;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SING:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg <= '0;
            out_valid_reg <= 1'b0;
            clip_reg <= 1'b0;
            q_reg[0] <= kf2_pkg::PROC_NOISE_RST;
            q_reg[1] <= '0;
            q_reg[2] <= '0;
            q_reg[3] <= kf2_pkg::PROC_NOISE_RST;
            r_reg[0] <= kf2_pkg::MEAS_NOISE_RST;
            r_reg[1] <= '0;
            r_reg[2] <= '0;
            r_reg[3] <= kf2_pkg::MEAS_NOISE_RST;
            cov_reg[0] <= kf2_pkg::COV_RST;
            cov_reg[1] <= '0;
            cov_reg[2] <= '0;
            cov_reg[3] <= kf2_pkg::COV_RST;
            est_reg[0] <= '0;
            est_reg[1] <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes, indexes past the list are dropped
            if (cfg_we)
            begin
                case (cfg_addr)
                    kf2_pkg::CFG_Q00: q_reg[0] <= cfg_data;
                    kf2_pkg::CFG_Q01: q_reg[1] <= cfg_data;
                    kf2_pkg::CFG_Q10: q_reg[2] <= cfg_data;
                    kf2_pkg::CFG_Q11: q_reg[3] <= cfg_data;
                    kf2_pkg::CFG_R00: r_reg[0] <= cfg_data;
                    kf2_pkg::CFG_R01: r_reg[1] <= cfg_data;
                    kf2_pkg::CFG_R10: r_reg[2] <= cfg_data;
                    kf2_pkg::CFG_R11: r_reg[3] <= cfg_data;
                    default: ;
                endcase
            end

            if (in_take)
            begin
                pc_reg <= '0;
                clip_reg <= 1'b0;
            end

            if ((state_reg == ST_EXEC) && (uop.op == kf2_pkg::OP_CHK) && (opnd_a != '0))
            begin
                pc_reg <= pc_reg + kf2_pkg::PC_W'(1);
            end

            if ((state_reg == ST_WAIT) && alu_rsp.done)
            begin
                clip_reg <= clip_reg | alu_rsp.clip;
                if (!last_step)
                begin
                    pc_reg <= pc_reg + kf2_pkg::PC_W'(1);
                end
                else
                begin
                    pc_reg <= '0;
                end
                // state write-back, each is the last use of the old value
                if (uop.dst[kf2_pkg::CODE_W-1])
                begin
                    case (uop.dst)
                        kf2_pkg::X_C0: cov_reg[0] <= alu_result;
                        kf2_pkg::X_C1: cov_reg[1] <= alu_result;
                        kf2_pkg::X_C2: cov_reg[2] <= alu_result;
                        kf2_pkg::X_C3: cov_reg[3] <= alu_result;
                        kf2_pkg::X_E0: est_reg[0] <= alu_result;
                        kf2_pkg::X_E1: est_reg[1] <= alu_result;
                        default: ;
                    endcase
                end
            end

            if (state_reg == ST_SING)
            begin
                pc_reg <= '0;
            end

            if (((state_reg == ST_DONE) || (state_reg == ST_SING)) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            z_reg[0] <= meas_a;
            z_reg[1] <= meas_b;
        end
        if (state_reg == ST_READ)
        begin
            ext_a_reg <= ext_sel(uop.a[3:0], q_reg[0], q_reg[1], q_reg[2], q_reg[3],
                                 r_reg[0], r_reg[1], r_reg[2], r_reg[3],
                                 cov_reg[0], cov_reg[1], cov_reg[2], cov_reg[3],
                                 est_reg[0], est_reg[1], z_reg[0], z_reg[1]);
            ext_b_reg <= ext_sel(uop.b[3:0], q_reg[0], q_reg[1], q_reg[2], q_reg[3],
                                 r_reg[0], r_reg[1], r_reg[2], r_reg[3],
                                 cov_reg[0], cov_reg[1], cov_reg[2], cov_reg[3],
                                 est_reg[0], est_reg[1], z_reg[0], z_reg[1]);
        end
        if (((state_reg == ST_DONE) || (state_reg == ST_SING)) && out_free)
        begin
            est_a_reg <= est_reg[0];
            est_b_reg <= est_reg[1];
            singular_reg <= state_reg == ST_SING;
            saturated_reg <= (state_reg == ST_DONE) && clip_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign est_a = est_a_reg;
    assign est_b = est_b_reg;
    assign singular = singular_reg;
    assign saturated = saturated_reg;

`ifndef SYNTHESIS
    // a singular result never reports clipping
    a_sing_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> !saturated)
        else $error("singular result flagged saturated");

    // the shared unit only answers while the sequencer waits on it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> state_reg == ST_WAIT)
        else $error("alu response outside wait state");

    // program counter stays inside the program
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg < kf2_pkg::PC_W'(kf2_pkg::PROG_LEN))
        else $error("program counter out of range");
`endif

endmodule
